/* design/drh_pkg.sv */
// Shared constants and types of the double rolling-hash matcher.
package drh_pkg;

  // Moduli, bases and the character offset of the two hash lanes
  localparam int WidthA = 30;
  localparam int WidthB = 31;
  localparam logic [30:0] ModA = 31'd1000000007;
  localparam logic [30:0] ModB = 31'd1500450271;
  localparam logic [7:0] BaseA = 8'd31;
  localparam logic [7:0] BaseB = 8'd29;
  localparam logic [8:0] CharOffset = 9'd47;

  // Function codes of an input item; the fourth code is unused
  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_PATTERN = 2'd1,
    FUNC_TEXT    = 2'd2
  } drh_func_e;

  // Work kinds handed from the front end to the hash back end
  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_FILL    = 2'd2,
    KIND_SLIDE   = 2'd3
  } drh_kind_e;

  // One queued operation
  typedef struct packed {
    drh_kind_e          kind;
    logic               check;
    logic signed [8:0]  s_new;
    logic signed [8:0]  s_old;
    logic [31:0]        pos;
  } drh_op_t;

  // Sequencer controls to each hash lane
  typedef struct packed {
    drh_kind_e          kind;
    logic               clear;
    logic               issue;
    logic               red_hi;
    logic               red_lo;
    logic               commit;
    logic signed [8:0]  s_new;
    logic signed [8:0]  s_old;
  } drh_lane_ctl_t;

endpackage

/* design/drh_item_if.sv */
// Input item channel of the matcher.
interface drh_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] char_code;

  modport source (output valid, func, char_code, input ready);
  modport sink   (input valid, func, char_code, output ready);
endinterface

/* design/drh_match_if.sv */
// Match position channel of the matcher.
interface drh_match_if;
  logic        valid;
  logic        ready;
  logic [31:0] match_start;

  modport source (output valid, match_start, input ready);
  modport sink   (input valid, match_start, output ready);
endinterface

/* design/drh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module drh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; a read at the written address returns the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/drh_front.sv */
// Front end: accept items, track counts and the text store, classify work.
module drh_front #(
  parameter int MAX_PATTERN   = 2048,
  parameter int POSITION_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  drh_item_if.sink          item_i,
  output drh_pkg::drh_op_t  op_o,
  output logic              op_valid_o,
  input  logic              full_i
);

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int CW = ((POSITION_BITS > LW) ? POSITION_BITS : LW) + 1;

  logic [POSITION_BITS-1:0] cnt_q, cnt_d;
  logic [LW-1:0]            len_q, len_d;
  logic [AW-1:0]            wp_q, wp_d;

  logic                     s1_valid_q;
  drh_pkg::drh_kind_e       s1_kind_q;
  logic                     s1_chk_q;
  logic signed [8:0]        s1_snew_q;
  logic [31:0]              s1_pos_q;

  logic                     accept;
  drh_pkg::drh_func_e       func_w;
  logic signed [8:0]        s_new_w;
  logic                     fwd;
  drh_pkg::drh_kind_e       kind;
  logic                     chk;
  logic                     ram_wr;
  logic [CW-1:0]            cnt_ext, len_ext, pos_ext;
  logic [LW:0]              idx_tmp;
  logic [AW-1:0]            old_idx;
  logic [7:0]               ram_rdata;

  assign item_i.ready = !s1_valid_q || !full_i;
  assign accept       = item_i.valid && item_i.ready;
  assign func_w       = drh_pkg::drh_func_e'(item_i.func);
  assign s_new_w      = $signed({1'b0, item_i.char_code} - drh_pkg::CharOffset);

  assign cnt_ext = CW'(cnt_q);
  assign len_ext = CW'(len_q);
  assign pos_ext = cnt_ext + CW'(1) - len_ext;

  // Locate the character that leaves the window
  always_comb begin
    idx_tmp = (LW + 1)'(wp_q) + (LW + 1)'(MAX_PATTERN) - (LW + 1)'(len_q);
    if (idx_tmp >= (LW + 1)'(MAX_PATTERN)) begin
      idx_tmp = idx_tmp - (LW + 1)'(MAX_PATTERN);
    end
    old_idx = idx_tmp[AW-1:0];
  end

  // Classify the item and step the counters
  always_comb begin
    cnt_d  = cnt_q;
    len_d  = len_q;
    wp_d   = wp_q;
    fwd    = 1'b0;
    kind   = drh_pkg::KIND_CLEAR;
    chk    = 1'b0;
    ram_wr = 1'b0;
    case (func_w)
      drh_pkg::FUNC_CLEAR: begin
        cnt_d = '0;
        len_d = '0;
        wp_d  = '0;
        fwd   = 1'b1;
      end
      drh_pkg::FUNC_PATTERN: begin
        if (cnt_q == '0 && len_q < LW'(MAX_PATTERN)) begin
          len_d = len_q + LW'(1);
          fwd   = 1'b1;
          kind  = drh_pkg::KIND_PATTERN;
        end
      end
      drh_pkg::FUNC_TEXT: begin
        if (cnt_q != '1) begin
          cnt_d = cnt_q + POSITION_BITS'(1);
          if (len_q != '0) begin
            fwd    = 1'b1;
            ram_wr = 1'b1;
            wp_d   = (wp_q == AW'(MAX_PATTERN - 1)) ? '0 : wp_q + AW'(1);
            if (cnt_ext < len_ext) begin
              kind = drh_pkg::KIND_FILL;
              chk  = (cnt_ext + CW'(1) == len_ext);
            end else begin
              kind = drh_pkg::KIND_SLIDE;
              chk  = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Hold the raw text of the last window
  drh_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PATTERN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && ram_wr),
    .waddr_i (wp_q),
    .wdata_i (item_i.char_code),
    .re_i    (accept && ram_wr),
    .raddr_i (old_idx),
    .rdata_o (ram_rdata)
  );

  // Advance the counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      len_q <= '0;
      wp_q  <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      len_q <= len_d;
      wp_q  <= wp_d;
    end
  end

  // Hold the classified item until the store read returns and the queue has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= fwd;
    end else if (!full_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q <= kind;
      s1_chk_q  <= chk;
      s1_snew_q <= s_new_w;
      s1_pos_q  <= 32'(pos_ext[POSITION_BITS-1:0]);
    end
  end

  assign op_valid_o  = s1_valid_q;
  assign op_o.kind   = s1_kind_q;
  assign op_o.check  = s1_chk_q;
  assign op_o.s_new  = s1_snew_q;
  assign op_o.s_old  = $signed({1'b0, ram_rdata} - drh_pkg::CharOffset);
  assign op_o.pos    = s1_pos_q;

endmodule

/* design/drh_queue.sv */
// Short FIFO of operations between the front and back ends.
module drh_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  drh_pkg::drh_op_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output drh_pkg::drh_op_t  data_o,
  output logic              valid_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  drh_pkg::drh_op_t mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [NW-1:0]    num_q;

  assign full_o  = (num_q == NW'(DEPTH));
  assign valid_o = (num_q != '0);
  assign data_o  = mem_q[rd_q];

  // Store pushed operations
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        num_q <= num_q + NW'(1);
      end else if (pop_i && !push_i) begin
        num_q <= num_q - NW'(1);
      end
    end
  end

endmodule

/* design/drh_lane.sv */
// One modular hash lane: pattern hash, scaled window sum and running powers.
module drh_lane #(
  parameter int LANE = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  drh_pkg::drh_lane_ctl_t ctl_i,
  output logic                   match_o
);

  localparam int W  = (LANE == 0) ? drh_pkg::WidthA : drh_pkg::WidthB;
  localparam int XW = W + 8;
  localparam logic [W-1:0] Mod  = (LANE == 0) ? drh_pkg::ModA[W-1:0] : drh_pkg::ModB[W-1:0];
  localparam logic [7:0]   Base = (LANE == 0) ? drh_pkg::BaseA : drh_pkg::BaseB;

  // hp_q is the pattern hash, scaled by B^i once the window slides
  logic [W-1:0]  hp_q, pp_q, f_q, pi_q, s_q;
  logic [XW-1:0] x_q [5];
  logic [XW-1:0] x_d [5];
  logic [XW-1:0] red [5];
  logic [1:0]    neg_q;

  logic [7:0]    u0, u1;
  logic [W-1:0]  src, acc, r0, r1, t0, t1, sum;
  logic [W:0]    sum1, sum2;

  function automatic logic [7:0] mag(logic signed [8:0] s);
    logic signed [8:0] a;
    a = (s < 0) ? -s : s;
    return a[7:0];
  endfunction

  // Four compare-subtract steps of the reduction by the modulus
  function automatic logic [XW-1:0] reduce4(logic [XW-1:0] x, logic hi);
    logic [XW-1:0] r;
    logic [XW-1:0] mm;
    r = x;
    for (int k = 0; k < 4; k++) begin
      mm = XW'(Mod) << (hi ? 7 - k : 3 - k);
      if (r >= mm) begin
        r = r - mm;
      end
    end
    return r;
  endfunction

  // Form the products of the step
  always_comb begin
    u0     = mag(ctl_i.s_new);
    u1     = (ctl_i.kind == drh_pkg::KIND_SLIDE) ? mag(ctl_i.s_old) : 8'd0;
    src    = (ctl_i.kind == drh_pkg::KIND_PATTERN) ? pp_q : f_q;
    x_d[0] = XW'(u0) * XW'(src);
    x_d[1] = XW'(u1) * XW'(pi_q);
    x_d[2] = XW'(Base) * XW'(src);
    x_d[3] = XW'(Base) * XW'(pi_q);
    x_d[4] = XW'(Base) * XW'(hp_q);
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      red[i] = reduce4(x_q[i], ctl_i.red_hi);
    end
  end

  // Apply signs and accumulate
  always_comb begin
    r0   = x_q[0][W-1:0];
    r1   = x_q[1][W-1:0];
    t0   = (neg_q[0] && r0 != '0) ? Mod - r0 : r0;
    t1   = (neg_q[1] && r1 != '0) ? Mod - r1 : r1;
    acc  = (ctl_i.kind == drh_pkg::KIND_PATTERN) ? hp_q : s_q;
    sum1 = {1'b0, acc} + {1'b0, t0};
    if (sum1 >= {1'b0, Mod}) begin
      sum1 = sum1 - {1'b0, Mod};
    end
    sum2 = {1'b0, sum1[W-1:0]} + {1'b0, t1};
    if (sum2 >= {1'b0, Mod}) begin
      sum2 = sum2 - {1'b0, Mod};
    end
    sum = sum2[W-1:0];
  end

  // Multiply and reduce
  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      x_q      <= x_d;
      neg_q[0] <= (ctl_i.s_new < 0);
      neg_q[1] <= (ctl_i.kind == drh_pkg::KIND_SLIDE) && (ctl_i.s_old >= 0);
    end else if (ctl_i.red_hi || ctl_i.red_lo) begin
      x_q <= red;
    end
  end

  // Update hashes and powers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q <= '0;
      pp_q <= W'(1);
      f_q  <= W'(1);
      pi_q <= W'(1);
      s_q  <= '0;
    end else if (ctl_i.clear) begin
      hp_q <= '0;
      pp_q <= W'(1);
      f_q  <= W'(1);
      pi_q <= W'(1);
      s_q  <= '0;
    end else if (ctl_i.commit) begin
      case (ctl_i.kind)
        drh_pkg::KIND_PATTERN: begin
          hp_q <= sum;
          pp_q <= x_q[2][W-1:0];
        end
        drh_pkg::KIND_FILL: begin
          s_q <= sum;
          f_q <= x_q[2][W-1:0];
        end
        drh_pkg::KIND_SLIDE: begin
          s_q  <= sum;
          f_q  <= x_q[2][W-1:0];
          pi_q <= x_q[3][W-1:0];
          hp_q <= x_q[4][W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign match_o = (s_q == hp_q);

endmodule

/* design/drh_back.sv */
// Back end: sequence the hash lanes and register match positions.
module drh_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drh_pkg::drh_op_t  op_i,
  input  logic              op_valid_i,
  output logic              op_pop_o,
  drh_match_if.source       match_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ISSUE  = 6'b000010,
    ST_RED_HI = 6'b000100,
    ST_RED_LO = 6'b001000,
    ST_COMMIT = 6'b010000,
    ST_CHECK  = 6'b100000
  } drh_state_e;

  drh_state_e             state_q, state_d;
  drh_pkg::drh_op_t       op_q;
  drh_pkg::drh_lane_ctl_t ctl;
  logic                   match_a, match_b;
  logic                   out_valid_q;
  logic [31:0]            out_data_q;
  logic                   out_free;

  assign op_pop_o = (state_q == ST_IDLE) && op_valid_i;
  assign out_free = !out_valid_q || match_o.ready;

  // Step the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (op_valid_i) state_d = ST_ISSUE;
      ST_ISSUE:  state_d = (op_q.kind == drh_pkg::KIND_CLEAR) ? ST_IDLE : ST_RED_HI;
      ST_RED_HI: state_d = ST_RED_LO;
      ST_RED_LO: state_d = ST_COMMIT;
      ST_COMMIT: state_d = op_q.check ? ST_CHECK : ST_IDLE;
      ST_CHECK:  if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      op_q <= op_i;
    end
  end

  // Drive both lanes
  always_comb begin
    ctl.kind   = op_q.kind;
    ctl.clear  = (state_q == ST_ISSUE) && (op_q.kind == drh_pkg::KIND_CLEAR);
    ctl.issue  = (state_q == ST_ISSUE) && (op_q.kind != drh_pkg::KIND_CLEAR);
    ctl.red_hi = (state_q == ST_RED_HI);
    ctl.red_lo = (state_q == ST_RED_LO);
    ctl.commit = (state_q == ST_COMMIT);
    ctl.s_new  = op_q.s_new;
    ctl.s_old  = op_q.s_old;
  end

  drh_lane #(.LANE(0)) u_lane_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .match_o (match_a)
  );

  drh_lane #(.LANE(1)) u_lane_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .match_o (match_b)
  );

  // Hold a match position until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_CHECK && out_free && match_a && match_b) begin
      out_valid_q <= 1'b1;
    end else if (match_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHECK && out_free) begin
      out_data_q <= op_q.pos;
    end
  end

  assign match_o.valid       = out_valid_q;
  assign match_o.match_start = out_data_q;

endmodule

/* design/double_rolling_hash_matcher_core.sv */
// Double rolling-hash substring matcher: top level.
// Items clear the search, append a pattern character or stream a text
// character; a result carries the start position of every text window whose
// two hashes (base 31 mod 1000000007, base 29 mod 1500450271) equal the
// pattern's, in ascending order. The front end accepts one item per cycle
// while its four-entry queue has room, keeps the counts and the last
// MAX_PATTERN text bytes in a RAM, and needs no clearing pass after reset or
// clear. For a pattern or text character the hash back end steps through
// queue pop, multiply, a high and a low reduction of four compare-subtract
// steps each, and accumulate, plus a check that waits for the match output
// when the window is checked; a clear takes only the pop and the issue step.
// The back end pops a new operation only when back in idle. The window sum
// is kept scaled by B^i for window start i and compared to the pattern hash
// scaled alike, which gives the same equality since both moduli are prime.
module double_rolling_hash_matcher_core #(
  parameter int MAX_PATTERN   = 2048,
  parameter int POSITION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  drh_item_if.sink    item_i,
  drh_match_if.source match_o
);

  drh_pkg::drh_op_t front_op, queue_op;
  logic             front_valid, queue_full, queue_valid, queue_pop;

  drh_front #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .op_o       (front_op),
    .op_valid_o (front_valid),
    .full_i     (queue_full)
  );

  drh_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid && !queue_full),
    .data_i  (front_op),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .data_o  (queue_op),
    .valid_o (queue_valid)
  );

  drh_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (queue_op),
    .op_valid_i (queue_valid),
    .op_pop_o   (queue_pop),
    .match_o    (match_o)
  );

endmodule
